// ===== rtl/tvh_pkg.sv =====
// ----------------------------------------------------------------------------
// Track identity vote histogram package
// Shared constants, status codes, the queue entry type and the confidence
// scaling function.
// ----------------------------------------------------------------------------
package tvh_pkg;

  localparam int DEF_PEOPLE       = 16;
  localparam int DEF_FACE_BINS    = 15;
  localparam int DEF_CANDIDATES   = 3;
  localparam int DEF_COUNT_WIDTH  = 16;

  localparam int INPUT_CANDIDATES = 3;
  localparam int SLOT_W           = 8;
  localparam int FACE_W           = 4;
  localparam int CONF_W           = 10;
  localparam int VOTE_W           = 4;
  localparam int QUEUE_DEPTH      = 2;

  localparam int RECIP_100        = 5243;
  localparam int RECIP_SHIFT      = 19;
  localparam int PROD_W           = CONF_W + 13;

  localparam logic [1:0] STAT_KNOWN = 2'd0;
  localparam logic [1:0] STAT_NEW   = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [SLOT_W-1:0]                         slot;
    logic [1:0]                                status;
    logic                                      seen;
    logic [INPUT_CANDIDATES-1:0][FACE_W-1:0]   face;
    logic [INPUT_CANDIDATES-1:0][VOTE_W-1:0]   vote;
  } cmd_t;

  // Confidence divided by one hundred, exact over the whole input range.
  function automatic logic [VOTE_W-1:0] conf_to_vote(input logic [CONF_W-1:0] conf);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(conf) * PROD_W'(RECIP_100);
    return prod[RECIP_SHIFT +: VOTE_W];
  endfunction

endpackage

// ===== rtl/track_identity_vote_histogram.sv =====
// ----------------------------------------------------------------------------
// Track identity vote histogram
// Maps body tracking ids to person indices and keeps per-person face votes.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A zero tracking id,
// or an unknown id without a face, is dropped and gives no result. Any
// other item gives one result, shown for a single cycle while done is high;
// the receiver cannot hold it off.
// The front end searches the tag table one entry per cycle and queues a
// command in a two-entry queue. The back end does a read and then a write
// of the vote memory for each valid candidate, then walks FACE_BINS plus
// one bins through its read port. The front takes a new item once its
// command is queued, so it may take new items while the back end is busy
// with earlier ones.
// After reset the vote memory, PEOPLE times (FACE_BINS plus one) entries,
// 256 at the defaults, is cleared while busy is held high.
// ----------------------------------------------------------------------------
module track_identity_vote_histogram
  import tvh_pkg::*;
#(
  parameter int PEOPLE      = DEF_PEOPLE,
  parameter int FACE_BINS   = DEF_FACE_BINS,
  parameter int CANDIDATES  = DEF_CANDIDATES,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] body_id,
  input  logic        face_seen,
  input  logic [3:0]  first_face_id,
  input  logic [9:0]  first_confidence,
  input  logic [3:0]  second_face_id,
  input  logic [9:0]  second_confidence,
  input  logic [3:0]  third_face_id,
  input  logic [9:0]  third_confidence,
  output logic        done,
  output logic [4:0]  person_index,
  output logic [3:0]  best_face_id,
  output logic [15:0] best_count,
  output logic [1:0]  status
);

  logic front_idle;
  logic clearing;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  assign busy = !front_idle || clearing;

  tvh_front #(.PEOPLE(PEOPLE)) u_front (
    .clk               (clk),
    .rst               (rst),
    .accept            (start && !busy),
    .body_id           (body_id),
    .face_seen         (face_seen),
    .first_face_id     (first_face_id),
    .first_confidence  (first_confidence),
    .second_face_id    (second_face_id),
    .second_confidence (second_confidence),
    .third_face_id     (third_face_id),
    .third_confidence  (third_confidence),
    .queue_full        (q_full),
    .idle              (front_idle),
    .push              (push),
    .push_cmd          (push_cmd)
  );

  tvh_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  tvh_back #(
    .PEOPLE      (PEOPLE),
    .FACE_BINS   (FACE_BINS),
    .CANDIDATES  (CANDIDATES),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (q_empty),
    .cmd          (pop_cmd),
    .pop          (pop),
    .clearing     (clearing),
    .done         (done),
    .person_index (person_index),
    .best_face_id (best_face_id),
    .best_count   (best_count),
    .status       (status)
  );

endmodule

// ===== rtl/tvh_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tvh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/tvh_fifo.sv =====
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out queue between the lookup and vote stages.
// ----------------------------------------------------------------------------
module tvh_fifo
  import tvh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] fill;

  assign full    = (fill == CW'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign pop_cmd = mem[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_cmd;
    end
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      fill <= fill + CW'(push) - CW'(pop);
    end
  end

endmodule

// ===== rtl/tvh_front.sv =====
// ----------------------------------------------------------------------------
// Lookup front end
// Takes items, searches the tag table, admits new persons and queues a
// command for the vote stage.
// ----------------------------------------------------------------------------
module tvh_front
  import tvh_pkg::*;
#(
  parameter int PEOPLE = DEF_PEOPLE
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [63:0]       body_id,
  input  logic              face_seen,
  input  logic [FACE_W-1:0] first_face_id,
  input  logic [CONF_W-1:0] first_confidence,
  input  logic [FACE_W-1:0] second_face_id,
  input  logic [CONF_W-1:0] second_confidence,
  input  logic [FACE_W-1:0] third_face_id,
  input  logic [CONF_W-1:0] third_confidence,
  input  logic              queue_full,
  output logic              idle,
  output logic              push,
  output cmd_t              push_cmd
);

  localparam int SW   = (PEOPLE > 1) ? $clog2(PEOPLE) : 1;
  localparam int CNTW = $clog2(PEOPLE + 1);

  typedef enum logic [1:0] {F_IDLE, F_SRCH, F_DEC} fstate_t;

  fstate_t                                 state;
  logic [63:0]                             tid;
  logic                                    seen;
  logic [INPUT_CANDIDATES-1:0][FACE_W-1:0] face;
  logic [INPUT_CANDIDATES-1:0][CONF_W-1:0] conf;
  logic [CNTW-1:0]                         count;
  logic [CNTW-1:0]                         idx;
  logic                                    rpend;
  logic [SW-1:0]                           ridx;
  logic                                    found;
  logic [SW-1:0]                           slot;

  logic            issue;
  logic            hit;
  logic            table_full;
  logic            drop;
  logic            tag_we;
  logic [63:0]     tag_rdata;
  logic [SW-1:0]   new_slot;

  tvh_ram #(.WIDTH(64), .DEPTH(PEOPLE)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (new_slot),
    .wdata (tid),
    .raddr (idx[SW-1:0]),
    .rdata (tag_rdata)
  );

  assign idle       = (state == F_IDLE);
  assign issue      = (state == F_SRCH) && (idx < count);
  assign hit        = rpend && (tag_rdata == tid);
  assign table_full = (count >= CNTW'(PEOPLE));
  assign drop       = !found && !seen;
  assign new_slot   = count[SW-1:0];
  assign push       = (state == F_DEC) && !drop && !queue_full;
  assign tag_we     = push && !found && !table_full;

  always_comb begin
    push_cmd.seen = seen;
    push_cmd.face = face;
    for (int i = 0; i < INPUT_CANDIDATES; i++) begin
      push_cmd.vote[i] = conf_to_vote(conf[i]);
    end
    if (found) begin
      push_cmd.slot   = SLOT_W'(slot);
      push_cmd.status = STAT_KNOWN;
    end else if (table_full) begin
      push_cmd.slot   = '0;
      push_cmd.status = STAT_FULL;
    end else begin
      push_cmd.slot   = SLOT_W'(new_slot);
      push_cmd.status = STAT_NEW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      count <= '0;
      rpend <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (accept && (body_id != '0)) begin
            tid     <= body_id;
            seen    <= face_seen;
            face[0] <= first_face_id;
            face[1] <= second_face_id;
            face[2] <= third_face_id;
            conf[0] <= first_confidence;
            conf[1] <= second_confidence;
            conf[2] <= third_confidence;
            idx     <= '0;
            rpend   <= 1'b0;
            found   <= 1'b0;
            state   <= F_SRCH;
          end
        end
        F_SRCH: begin
          rpend <= issue && !hit;
          ridx  <= idx[SW-1:0];
          if (issue) begin
            idx <= idx + 1'b1;
          end
          if (hit) begin
            found <= 1'b1;
            slot  <= ridx;
            state <= F_DEC;
          end else if (!issue && !rpend) begin
            state <= F_DEC;
          end
        end
        F_DEC: begin
          if (drop) begin
            state <= F_IDLE;
          end else if (!queue_full) begin
            if (tag_we) begin
              count <= count + 1'b1;
            end
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/tvh_back.sv =====
// ----------------------------------------------------------------------------
// Vote back end
// Adds candidate votes to a person's bins, walks the bins for the best face
// identity and emits the result; a table-full command gives a zero result.
// ----------------------------------------------------------------------------
module tvh_back
  import tvh_pkg::*;
#(
  parameter int PEOPLE      = DEF_PEOPLE,
  parameter int FACE_BINS   = DEF_FACE_BINS,
  parameter int CANDIDATES  = DEF_CANDIDATES,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  cmd_t        cmd,
  output logic        pop,
  output logic        clearing,
  output logic        done,
  output logic [4:0]  person_index,
  output logic [3:0]  best_face_id,
  output logic [15:0] best_count,
  output logic [1:0]  status
);

  localparam int BINS  = FACE_BINS + 1;
  localparam int DEPTH = PEOPLE * BINS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = $clog2(BINS);
  localparam int CW    = COUNT_WIDTH;
  localparam int LIM   = (CANDIDATES < INPUT_CANDIDATES) ? CANDIDATES : INPUT_CANDIDATES;
  localparam int CIW   = $clog2(INPUT_CANDIDATES + 1);

  typedef enum logic [2:0] {B_CLR, B_IDLE, B_VRD, B_VWR, B_WALK} bstate_t;

  bstate_t       state;
  logic [AW-1:0] clr_addr;
  cmd_t          cur;
  logic [CIW-1:0] cidx;
  logic [BW:0]   widx;
  logic          rpend;
  logic [BW-1:0] ridx;
  logic [CW-1:0] bestv;
  logic [BW-1:0] best;
  logic [CW-1:0] cnt;

  logic [AW-1:0]     base;
  logic [FACE_W-1:0] cface;
  logic [VOTE_W-1:0] cvote;
  logic              face_ok;
  logic [AW-1:0]     cand_addr;
  logic [AW-1:0]     walk_addr;
  logic              issue;
  logic [CW-1:0]     rdata;
  logic [CW:0]       sum;
  logic [CW-1:0]     satv;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [CW-1:0]     ram_wdata;
  logic              gt;
  logic [BW-1:0]     nbest;
  logic [CW-1:0]     nbestv;
  logic [CW-1:0]     ncnt;

  tvh_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_vote_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rdata)
  );

  assign base      = AW'(32'(cur.slot) * BINS);
  assign cface     = cur.face[cidx[1:0]];
  assign cvote     = cur.vote[cidx[1:0]];
  assign face_ok   = (32'(cface) <= FACE_BINS);
  assign cand_addr = base + AW'(cface);
  assign walk_addr = base + AW'(widx[BW-1:0]);
  assign issue     = (state == B_WALK) && (32'(widx) <= FACE_BINS);
  assign sum       = {1'b0, rdata} + (CW + 1)'(cvote);
  assign satv      = sum[CW] ? '1 : sum[CW-1:0];
  assign clearing  = (state == B_CLR);
  assign pop       = (state == B_IDLE) && !empty;

  assign ram_we    = (state == B_CLR) || (state == B_VWR);
  assign ram_waddr = (state == B_CLR) ? clr_addr : cand_addr;
  assign ram_wdata = (state == B_CLR) ? '0 : satv;
  assign ram_raddr = (state == B_VRD) ? cand_addr : walk_addr;

  assign gt     = (rdata > bestv);
  assign nbest  = (ridx == '0) ? '0 : (gt ? ridx : best);
  assign nbestv = (ridx == '0) ? rdata : (gt ? rdata : bestv);
  assign ncnt   = (ridx == '0) ? '0 : (gt ? rdata : cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLR;
      clr_addr <= '0;
      rpend    <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        B_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!empty) begin
            cur   <= cmd;
            cidx  <= '0;
            widx  <= '0;
            rpend <= 1'b0;
            if (cmd.status == STAT_FULL) begin
              done         <= 1'b1;
              person_index <= '0;
              best_face_id <= '0;
              best_count   <= '0;
              status       <= STAT_FULL;
            end else begin
              state <= cmd.seen ? B_VRD : B_WALK;
            end
          end
        end
        B_VRD: begin
          if (cidx == CIW'(LIM)) begin
            state <= B_WALK;
          end else if (face_ok) begin
            state <= B_VWR;
          end else begin
            cidx <= cidx + 1'b1;
          end
        end
        B_VWR: begin
          cidx  <= cidx + 1'b1;
          state <= B_VRD;
        end
        B_WALK: begin
          rpend <= issue;
          ridx  <= widx[BW-1:0];
          if (issue) begin
            widx <= widx + 1'b1;
          end
          if (rpend) begin
            best  <= nbest;
            bestv <= nbestv;
            cnt   <= ncnt;
            if (ridx == BW'(FACE_BINS)) begin
              done         <= 1'b1;
              person_index <= 5'(32'(cur.slot) + 1);
              best_face_id <= 4'(nbest);
              best_count   <= 16'(ncnt);
              status       <= cur.status;
              state        <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/tvh_checker.sv =====
// ----------------------------------------------------------------------------
// Track identity vote histogram checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module tvh_checker
  import tvh_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic [4:0]  person_index,
  input logic [3:0]  best_face_id,
  input logic [15:0] best_count,
  input logic [1:0]  status
);

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == STAT_KNOWN || status == STAT_NEW || status == STAT_FULL))
    else $error("result status code out of range");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (done && status == STAT_FULL) |->
      (person_index == 5'd0 && best_face_id == 4'd0 && best_count == 16'd0))
    else $error("table full result carries data");

  a_person_index: assert property (@(posedge clk) disable iff (rst)
    (done && status != STAT_FULL) |-> (person_index != 5'd0))
    else $error("assigned person has index zero");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!done && busy))
    else $error("activity right after reset");

endmodule

bind track_identity_vote_histogram tvh_checker u_tvh_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .done         (done),
  .person_index (person_index),
  .best_face_id (best_face_id),
  .best_count   (best_count),
  .status       (status)
);
